FILE: src/imuf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// imuf_pkg
// Shared types, constants and arithmetic helpers of the IMU/odometry fusion
// core.
// ============================================================================
package imuf_pkg;

    localparam int C_TRIG_BITS = 10;
    localparam logic [15:0] C_ANG_MASK =
        16'(((1 << C_TRIG_BITS) - 1) << (16 - C_TRIG_BITS));
    localparam logic [14:0] C_QUARTER = 15'd16384;

    localparam logic signed [17:0] C_SIN_A   = 18'sd2385;
    localparam logic signed [57:0] C_SIN_B   = 58'sd21089;
    localparam logic signed [57:0] C_SIN_C   = 58'sd51472;
    localparam logic signed [17:0] C_G_IN_Q8 = 18'sd98839;
    localparam logic [17:0]        C_ONE_Q16 = 18'd65536;

    localparam logic [15:0] C_ALPHA_RST  = 16'd64225;
    localparam logic [15:0] C_DECAY_RST  = 16'd64881;
    localparam logic [15:0] C_PERIOD_RST = 16'd1311;

    localparam int C_QUEUE_DEPTH = 2;
    localparam int C_QPTR_W      = $clog2(C_QUEUE_DEPTH);
    localparam int C_QCNT_W      = $clog2(C_QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CFG_BLEND_ALPHA    = 3'd0,
        CFG_VELOCITY_DECAY = 3'd1,
        CFG_TICK_PERIOD    = 3'd2,
        CFG_FORWARD_NEGATE = 3'd3,
        CFG_LATERAL_NEGATE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] blend_alpha;
        logic [15:0] velocity_decay;
        logic [15:0] tick_period;
        logic        forward_negate;
        logic        lateral_negate;
    } t_cfg;

    typedef struct packed {
        logic               cmd_seed;
        logic signed [16:0] lat;
        logic signed [16:0] fwd;
        logic [14:0]        u_sin;
        logic [14:0]        u_cos;
        logic               neg_sin;
        logic               neg_cos;
        logic signed [31:0] odom_x;
        logic signed [31:0] odom_y;
    } t_job;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SEED, ST_K,
        ST_T2S, ST_T2C, ST_PS, ST_PC, ST_QS, ST_QC, ST_SS, ST_SC,
        ST_DX, ST_LC, ST_FS, ST_FC, ST_LS, ST_HX, ST_DY, ST_HY,
        ST_KHX, ST_KLX, ST_KHY, ST_KLY, ST_VPX, ST_OX, ST_VPY,
        ST_PX, ST_OY, ST_PY, ST_FIN, ST_DONE
    } t_back_state;

    // round half up: floor((v + 2^(s-1)) / 2^s)
    function automatic logic signed [57:0] f_rnd(input logic signed [57:0] v,
                                                 input int unsigned s);
        logic signed [57:0] t;
        t = v + (58'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    // clamp to the signed w-bit range
    function automatic logic signed [57:0] f_sat(input logic signed [57:0] v,
                                                 input int unsigned w);
        logic signed [57:0] hi;
        logic signed [57:0] lo;
        hi = (58'sd1 <<< (w - 1)) - 58'sd1;
        lo = -hi - 58'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

FILE: src/imuf_front.sv
`timescale 1ns / 1ps
// ============================================================================
// imuf_front
// Input stage: takes stream items, applies axis signs and splits the heading
// into quadrant signs and quarter-wave arguments for sine and cosine.
// ============================================================================
module imuf_front
    import imuf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [111:0] i_s_tdata,   // accel_lateral, accel_forward, heading_angle,
                                      // odom_pos_x, odom_pos_y
    input  logic         i_s_tuser,   // command
    output logic         o_job_valid,
    input  logic         i_job_ready,
    output t_job         o_job
);

    logic               r_valid;
    t_job               r_job;
    t_job               w_job;
    logic signed [16:0] w_lat;
    logic signed [16:0] w_fwd;
    logic [15:0]        w_ang;
    logic [14:0]        w_rem;
    logic [14:0]        w_rem_inv;

    assign o_s_tready  = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        w_lat     = {i_s_tdata[15], i_s_tdata[15:0]};
        w_fwd     = {i_s_tdata[31], i_s_tdata[31:16]};
        w_ang     = i_s_tdata[47:32] & C_ANG_MASK;
        w_rem     = {1'b0, w_ang[13:0]};
        w_rem_inv = C_QUARTER - w_rem;

        w_job.cmd_seed = i_s_tuser;
        w_job.lat      = i_cfg.lateral_negate ? 17'sd0 - w_lat : w_lat;
        w_job.fwd      = i_cfg.forward_negate ? 17'sd0 - w_fwd : w_fwd;
        w_job.u_sin    = w_ang[14] ? w_rem_inv : w_rem;
        w_job.u_cos    = w_ang[14] ? w_rem : w_rem_inv;
        w_job.neg_sin  = w_ang[15];
        w_job.neg_cos  = w_ang[15] ^ w_ang[14];
        w_job.odom_x   = i_s_tdata[79:48];
        w_job.odom_y   = i_s_tdata[111:80];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_job <= w_job;
        end
    end

endmodule

FILE: src/imuf_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// imuf_queue
// Short job queue between the input stage and the filter sequencer.
// ============================================================================
module imuf_queue
    import imuf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_enq_valid,
    output logic o_enq_ready,
    input  t_job i_enq_job,
    output logic o_deq_valid,
    input  logic i_deq_ready,
    output t_job o_deq_job
);

    t_job                r_mem [C_QUEUE_DEPTH];
    logic [C_QPTR_W-1:0] r_wr_ptr;
    logic [C_QPTR_W-1:0] r_rd_ptr;
    logic [C_QCNT_W-1:0] r_count;
    logic                w_push;
    logic                w_pop;

    assign o_enq_ready = r_count != C_QCNT_W'(C_QUEUE_DEPTH);
    assign o_deq_valid = r_count != '0;
    assign o_deq_job   = r_mem[r_rd_ptr];
    assign w_push      = i_enq_valid && o_enq_ready;
    assign w_pop       = o_deq_valid && i_deq_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == C_QPTR_W'(C_QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == C_QPTR_W'(C_QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10: begin
                    r_count <= r_count + 1'b1;
                end
                2'b01: begin
                    r_count <= r_count - 1'b1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_enq_job;
        end
    end

endmodule

FILE: src/imuf_back.sv
`timescale 1ns / 1ps
// ============================================================================
// imuf_back
// Filter sequencer: one shared 34x18 multiplier runs sine/cosine, rotation,
// high-pass, velocity and position blend for both axes, then registers the
// result item.
// ============================================================================
module imuf_back
    import imuf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_job_valid,
    output logic         o_job_ready,
    input  t_job         i_job,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata    // fused_pos_x, fused_pos_y, velocity_x, velocity_y
);

    t_back_state r_state;
    t_back_state n_state;

    logic signed [16:0] r_lat;
    logic signed [16:0] r_fwd;
    logic [14:0]        r_us;
    logic [14:0]        r_uc;
    logic               r_neg_s;
    logic               r_neg_c;
    logic signed [31:0] r_odx;
    logic signed [31:0] r_ody;
    logic signed [51:0] r_prod;
    logic [32:0]        r_k;
    logic [14:0]        r_ts;
    logic [14:0]        r_tc;
    logic [14:0]        r_ps;
    logic [14:0]        r_pc;
    logic [15:0]        r_qs;
    logic [15:0]        r_qc;
    logic signed [16:0] r_sin;
    logic signed [16:0] r_cos;
    logic signed [57:0] r_acc;
    logic signed [17:0] r_ax;
    logic signed [17:0] r_ay;
    logic signed [25:0] r_dx;
    logic signed [25:0] r_dy;
    logic signed [32:0] r_vd_x;
    logic signed [32:0] r_vd_y;
    logic signed [29:0] r_vi_x;
    logic signed [29:0] r_vi_y;
    logic signed [33:0] r_sum_x;
    logic signed [33:0] r_sum_y;

    logic signed [17:0] r_prev_x;
    logic signed [17:0] r_prev_y;
    logic signed [23:0] r_hp_x;
    logic signed [23:0] r_hp_y;
    logic signed [31:0] r_vel_x;
    logic signed [31:0] r_vel_y;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;

    logic               r_out_valid;
    logic [127:0]       r_out_data;

    logic signed [33:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [51:0] w_mul_p;
    logic               w_out_load;
    logic signed [57:0] w_prod_x;
    logic signed [57:0] w_sum;
    logic signed [57:0] w_diff;
    logic signed [57:0] w_r14;
    logic signed [57:0] w_neg14;
    logic signed [57:0] w_r16;
    logic signed [57:0] w_poly_p;
    logic signed [57:0] w_poly_q;
    logic signed [57:0] w_sum_r15;
    logic signed [57:0] w_diff_r15;
    logic signed [57:0] w_sum_r28;
    logic signed [57:0] w_sum_r16;
    logic signed [57:0] w_hp_sat;
    logic signed [57:0] w_vel_x_sum;
    logic signed [57:0] w_vel_y_sum;
    logic signed [57:0] w_vel_x_sat;
    logic signed [57:0] w_vel_y_sat;
    logic signed [57:0] w_pos_sat;
    logic [17:0]        w_alpha_c;

    assign w_mul_p     = w_mul_a * w_mul_b;
    assign w_prod_x    = {{6{r_prod[51]}}, r_prod};
    assign w_sum       = r_acc + w_prod_x;
    assign w_diff      = r_acc - w_prod_x;
    assign w_r14       = f_rnd(w_prod_x, 14);
    assign w_neg14     = 58'sd0 - w_r14;
    assign w_r16       = f_rnd(w_prod_x, 16);
    assign w_poly_p    = C_SIN_B - w_r14;
    assign w_poly_q    = C_SIN_C - w_r14;
    assign w_sum_r15   = f_rnd(w_sum, 15);
    assign w_diff_r15  = f_rnd(w_diff, 15);
    assign w_sum_r28   = f_rnd(w_sum, 28);
    assign w_sum_r16   = f_rnd(w_sum, 16);
    assign w_hp_sat    = f_sat(w_r16, 24);
    assign w_vel_x_sum = {{25{r_vd_x[32]}}, r_vd_x} + {{28{r_vi_x[29]}}, r_vi_x};
    assign w_vel_y_sum = {{25{r_vd_y[32]}}, r_vd_y} + {{28{r_vi_y[29]}}, r_vi_y};
    assign w_vel_x_sat = f_sat(w_vel_x_sum, 32);
    assign w_vel_y_sat = f_sat(w_vel_y_sum, 32);
    assign w_pos_sat   = f_sat(w_sum_r16, 32);
    assign w_alpha_c   = C_ONE_Q16 - {2'd0, i_cfg.blend_alpha};

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.cmd_seed ? ST_SEED : ST_K;
                end
            end
            ST_SEED: n_state = ST_DONE;
            ST_K:    n_state = ST_T2S;
            ST_T2S:  n_state = ST_T2C;
            ST_T2C:  n_state = ST_PS;
            ST_PS:   n_state = ST_PC;
            ST_PC:   n_state = ST_QS;
            ST_QS:   n_state = ST_QC;
            ST_QC:   n_state = ST_SS;
            ST_SS:   n_state = ST_SC;
            ST_SC:   n_state = ST_DX;
            ST_DX:   n_state = ST_LC;
            ST_LC:   n_state = ST_FS;
            ST_FS:   n_state = ST_FC;
            ST_FC:   n_state = ST_LS;
            ST_LS:   n_state = ST_HX;
            ST_HX:   n_state = ST_DY;
            ST_DY:   n_state = ST_HY;
            ST_HY:   n_state = ST_KHX;
            ST_KHX:  n_state = ST_KLX;
            ST_KLX:  n_state = ST_KHY;
            ST_KHY:  n_state = ST_KLY;
            ST_KLY:  n_state = ST_VPX;
            ST_VPX:  n_state = ST_OX;
            ST_OX:   n_state = ST_VPY;
            ST_VPY:  n_state = ST_PX;
            ST_PX:   n_state = ST_OY;
            ST_OY:   n_state = ST_PY;
            ST_PY:   n_state = ST_FIN;
            ST_FIN:  n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = 1'b0;
        w_out_load  = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        case (r_state)
            ST_IDLE: begin
                o_job_ready = 1'b1;
            end
            ST_DONE: begin
                w_out_load = !r_out_valid || i_m_tready;
            end
            ST_K: begin
                w_mul_a = {18'd0, i_cfg.tick_period};
                w_mul_b = C_G_IN_Q8;
            end
            ST_T2S: begin
                w_mul_a = {19'd0, r_us};
                w_mul_b = {3'd0, r_us};
            end
            ST_T2C: begin
                w_mul_a = {19'd0, r_uc};
                w_mul_b = {3'd0, r_uc};
            end
            ST_PS: begin
                w_mul_a = {19'd0, r_ts};
                w_mul_b = C_SIN_A;
            end
            ST_PC: begin
                w_mul_a = {19'd0, r_tc};
                w_mul_b = C_SIN_A;
            end
            ST_QS: begin
                w_mul_a = {19'd0, r_ps};
                w_mul_b = {3'd0, r_ts};
            end
            ST_QC: begin
                w_mul_a = {19'd0, r_pc};
                w_mul_b = {3'd0, r_tc};
            end
            ST_SS: begin
                w_mul_a = {18'd0, r_qs};
                w_mul_b = {3'd0, r_us};
            end
            ST_SC: begin
                w_mul_a = {18'd0, r_qc};
                w_mul_b = {3'd0, r_uc};
            end
            ST_DX: begin
                w_mul_a = {{2{r_vel_x[31]}}, r_vel_x};
                w_mul_b = {2'd0, i_cfg.velocity_decay};
            end
            ST_LC: begin
                w_mul_a = {{17{r_lat[16]}}, r_lat};
                w_mul_b = {r_cos[16], r_cos};
            end
            ST_FS: begin
                w_mul_a = {{17{r_fwd[16]}}, r_fwd};
                w_mul_b = {r_sin[16], r_sin};
            end
            ST_FC: begin
                w_mul_a = {{17{r_fwd[16]}}, r_fwd};
                w_mul_b = {r_cos[16], r_cos};
            end
            ST_LS: begin
                w_mul_a = {{17{r_lat[16]}}, r_lat};
                w_mul_b = {r_sin[16], r_sin};
            end
            ST_HX: begin
                w_mul_a = {{8{r_dx[25]}}, r_dx};
                w_mul_b = {2'd0, i_cfg.blend_alpha};
            end
            ST_DY: begin
                w_mul_a = {{2{r_vel_y[31]}}, r_vel_y};
                w_mul_b = {2'd0, i_cfg.velocity_decay};
            end
            ST_HY: begin
                w_mul_a = {{8{r_dy[25]}}, r_dy};
                w_mul_b = {2'd0, i_cfg.blend_alpha};
            end
            ST_KHX: begin
                w_mul_a = {{10{r_hp_x[23]}}, r_hp_x};
                w_mul_b = {2'd0, r_k[32:17]};
            end
            ST_KLX: begin
                w_mul_a = {{10{r_hp_x[23]}}, r_hp_x};
                w_mul_b = {1'b0, r_k[16:0]};
            end
            ST_KHY: begin
                w_mul_a = {{10{r_hp_y[23]}}, r_hp_y};
                w_mul_b = {2'd0, r_k[32:17]};
            end
            ST_KLY: begin
                w_mul_a = {{10{r_hp_y[23]}}, r_hp_y};
                w_mul_b = {1'b0, r_k[16:0]};
            end
            ST_VPX: begin
                w_mul_a = {{2{r_vel_x[31]}}, r_vel_x};
                w_mul_b = {2'd0, i_cfg.tick_period};
            end
            ST_OX: begin
                w_mul_a = {{2{r_odx[31]}}, r_odx};
                w_mul_b = w_alpha_c;
            end
            ST_VPY: begin
                w_mul_a = {{2{r_vel_y[31]}}, r_vel_y};
                w_mul_b = {2'd0, i_cfg.tick_period};
            end
            ST_PX: begin
                w_mul_a = r_sum_x;
                w_mul_b = {2'd0, i_cfg.blend_alpha};
            end
            ST_OY: begin
                w_mul_a = {{2{r_ody[31]}}, r_ody};
                w_mul_b = w_alpha_c;
            end
            ST_PY: begin
                w_mul_a = r_sum_y;
                w_mul_b = {2'd0, i_cfg.blend_alpha};
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // filter state and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_hp_x      <= '0;
            r_hp_y      <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_SEED: begin
                    r_prev_x <= '0;
                    r_prev_y <= '0;
                    r_hp_x   <= '0;
                    r_hp_y   <= '0;
                    r_vel_x  <= '0;
                    r_vel_y  <= '0;
                    r_pos_x  <= r_odx;
                    r_pos_y  <= r_ody;
                end
                ST_LS: begin
                    r_prev_x <= r_ax;
                end
                ST_DY: begin
                    r_prev_y <= r_ay;
                    r_hp_x   <= w_hp_sat[23:0];
                end
                ST_KHX: begin
                    r_hp_y <= w_hp_sat[23:0];
                end
                ST_KLY: begin
                    r_vel_x <= w_vel_x_sat[31:0];
                end
                ST_OX: begin
                    r_vel_y <= w_vel_y_sat[31:0];
                end
                ST_OY: begin
                    r_pos_x <= w_pos_sat[31:0];
                end
                ST_FIN: begin
                    r_pos_y <= w_pos_sat[31:0];
                end
                default: begin
                    r_pos_y <= r_pos_y;
                end
            endcase
        end
    end

    // operands and intermediate products
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p;
        if (w_out_load) begin
            r_out_data <= {r_vel_y, r_vel_x, r_pos_y, r_pos_x};
        end
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    r_lat   <= i_job.lat;
                    r_fwd   <= i_job.fwd;
                    r_us    <= i_job.u_sin;
                    r_uc    <= i_job.u_cos;
                    r_neg_s <= i_job.neg_sin;
                    r_neg_c <= i_job.neg_cos;
                    r_odx   <= i_job.odom_x;
                    r_ody   <= i_job.odom_y;
                end
            end
            ST_T2S: r_k  <= r_prod[32:0];
            ST_T2C: r_ts <= w_r14[14:0];
            ST_PS:  r_tc <= w_r14[14:0];
            ST_PC:  r_ps <= w_poly_p[14:0];
            ST_QS:  r_pc <= w_poly_p[14:0];
            ST_QC:  r_qs <= w_poly_q[15:0];
            ST_SS:  r_qc <= w_poly_q[15:0];
            ST_SC:  r_sin <= r_neg_s ? w_neg14[16:0] : w_r14[16:0];
            ST_DX:  r_cos <= r_neg_c ? w_neg14[16:0] : w_r14[16:0];
            ST_LC:  r_vd_x <= w_r16[32:0];
            ST_FS:  r_acc <= w_prod_x;
            ST_FC:  r_ax <= w_sum_r15[17:0];
            ST_LS: begin
                r_acc <= w_prod_x;
                r_dx  <= {{2{r_hp_x[23]}}, r_hp_x} + {{8{r_ax[17]}}, r_ax}
                         - {{8{r_prev_x[17]}}, r_prev_x};
            end
            ST_HX:  r_ay <= w_diff_r15[17:0];
            ST_DY: begin
                r_dy <= {{2{r_hp_y[23]}}, r_hp_y} + {{8{r_ay[17]}}, r_ay}
                        - {{8{r_prev_y[17]}}, r_prev_y};
            end
            ST_HY:  r_vd_y <= w_r16[32:0];
            ST_KLX: r_acc <= w_prod_x <<< 17;
            ST_KHY: r_vi_x <= w_sum_r28[29:0];
            ST_KLY: r_acc <= w_prod_x <<< 17;
            ST_VPX: r_vi_y <= w_sum_r28[29:0];
            ST_OX:  r_sum_x <= {{2{r_pos_x[31]}}, r_pos_x} + w_r16[33:0];
            ST_VPY: r_acc <= w_prod_x;
            ST_PX:  r_sum_y <= {{2{r_pos_y[31]}}, r_pos_y} + w_r16[33:0];
            ST_PY:  r_acc <= w_prod_x;
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

endmodule

FILE: src/imu_odometry_complementary_fusion_core.sv
`timescale 1ns / 1ps
// ============================================================================
// imu_odometry_complementary_fusion_core
// 2-D IMU/odometry complementary position fusion, fixed point.
// ============================================================================
// Each input item is either a tick (command 0: accelerometer pair, heading,
// odometry) or a reset command (command 1: clear the filters and seed the
// fused position from odometry); every item yields exactly one result item
// with fused position and velocity. Items pass an input register and a
// two-entry queue into a sequencer built around one shared 34x18 multiplier:
// a tick takes fetch, 27 multiply steps, a final position write and result
// hand-off, a reset command only fetch, seed and hand-off. The sequencer
// takes a new item only once the last result is handed off. Configuration
// writes are always ready and take effect on the next item; write them only
// while no item is in flight.
// ============================================================================
module imu_odometry_complementary_fusion_core
    import imuf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [111:0] i_s_tdata,   // accel_lateral, accel_forward, heading_angle,
                                      // odom_pos_x, odom_pos_y
    input  logic         i_s_tuser,   // command
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata    // fused_pos_x, fused_pos_y, velocity_x, velocity_y
);

    t_cfg r_cfg;
    logic w_job_valid;
    logic w_job_ready;
    t_job w_job;
    logic w_deq_valid;
    logic w_deq_ready;
    t_job w_deq_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blend_alpha    <= C_ALPHA_RST;
            r_cfg.velocity_decay <= C_DECAY_RST;
            r_cfg.tick_period    <= C_PERIOD_RST;
            r_cfg.forward_negate <= 1'b0;
            r_cfg.lateral_negate <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BLEND_ALPHA:    r_cfg.blend_alpha    <= i_cfg_data;
                CFG_VELOCITY_DECAY: r_cfg.velocity_decay <= i_cfg_data;
                CFG_TICK_PERIOD:    r_cfg.tick_period    <= i_cfg_data;
                CFG_FORWARD_NEGATE: r_cfg.forward_negate <= i_cfg_data[0];
                CFG_LATERAL_NEGATE: r_cfg.lateral_negate <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    imuf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready),
        .o_job       (w_job)
    );

    imuf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enq_valid (w_job_valid),
        .o_enq_ready (w_job_ready),
        .i_enq_job   (w_job),
        .o_deq_valid (w_deq_valid),
        .i_deq_ready (w_deq_ready),
        .o_deq_job   (w_deq_job)
    );

    imuf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_deq_valid),
        .o_job_ready (w_deq_ready),
        .i_job       (w_deq_job),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    a_accept_to_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> w_job_valid)
        else $error("accepted item did not reach the queue input");

    a_one_job_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_deq_valid && w_deq_ready) |=> !w_deq_ready)
        else $error("sequencer fetched a job while busy");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the IMU/odometry complementary fusion core.
// ============================================================================
// Drives ticks and seed commands into the stream input and checks every fused
// pose against a fixed-point predictor of the block. The predictor covers the
// heading rotation, high-pass filter, leaky velocity integrator and odometry
// blend. A directed part covers field extremes, heading quadrants, negated
// full-scale samples, saturation and a zero tick period. Random phases follow
// under changing register settings, with bursts of idle and stall on both
// streams and one long output hold-off that backs up the input.
// ============================================================================
module testbench;
    import imuf_pkg::*;

    localparam int ANGLE_BITS = 10;
    localparam logic [15:0] ANGLE_MASK = 16'(((1 << ANGLE_BITS) - 1) << (16 - ANGLE_BITS));
    localparam longint G_IN_Q8 = 98839;
    localparam longint ONE_Q16 = 65536;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 135;

    typedef struct packed {
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } pose_t;

    class fusion_scoreboard;
        longint alpha, decay, period;
        bit neg_fwd, neg_lat;
        longint prev_a[2], hp[2], vel[2], pos[2];
        pose_t expected_poses[$];
        int errors, checked, ticks, seeds;

        function new();
            alpha = 64225;
            decay = 64881;
            period = 1311;
            neg_fwd = 1'b0;
            neg_lat = 1'b0;
            for (int k = 0; k < 2; k++) begin
                prev_a[k] = 0;
                hp[k] = 0;
                vel[k] = 0;
                pos[k] = 0;
            end
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint clamp_signed(longint v, int w);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function longint poly_sine(longint u);
            longint t2;
            longint p;
            longint q;
            t2 = round_shift(u * u, 14);
            p = 21089 - round_shift(2385 * t2, 14);
            q = 51472 - round_shift(p * t2, 14);
            return round_shift(q * u, 14);
        endfunction

        function longint bam_sine(logic [15:0] a);
            longint r;
            longint v;
            r = longint'(a[13:0]);
            v = poly_sine(a[14] ? 16384 - r : r);
            return a[15] ? -v : v;
        endfunction

        function void update_axis(int k, longint a, longint odom);
            hp[k] = clamp_signed(round_shift(alpha * (hp[k] + a - prev_a[k]), 16), 24);
            prev_a[k] = a;
            vel[k] = clamp_signed(round_shift(vel[k] * decay, 16)
                                  + round_shift(hp[k] * G_IN_Q8 * period, 28), 32);
            pos[k] = clamp_signed(round_shift(alpha * (pos[k] + round_shift(vel[k] * period, 16))
                                              + (ONE_Q16 - alpha) * odom, 16), 32);
        endfunction

        function void set_register(logic [2:0] idx, logic [15:0] value);
            case (idx)
                CFG_BLEND_ALPHA:    alpha = longint'(value);
                CFG_VELOCITY_DECAY: decay = longint'(value);
                CFG_TICK_PERIOD:    period = longint'(value);
                CFG_FORWARD_NEGATE: neg_fwd = value[0];
                CFG_LATERAL_NEGATE: neg_lat = value[0];
                default: ;
            endcase
        endfunction

        function void note_item(logic cmd, logic [111:0] d);
            longint lat, fwd, odx, ody, s, c, ax, ay;
            logic [15:0] ang_sin;
            logic [15:0] ang_cos;
            pose_t p;
            odx = longint'($signed(d[79:48]));
            ody = longint'($signed(d[111:80]));
            if (cmd) begin
                for (int k = 0; k < 2; k++) begin
                    prev_a[k] = 0;
                    hp[k] = 0;
                    vel[k] = 0;
                end
                pos[0] = odx;
                pos[1] = ody;
                seeds++;
            end else begin
                lat = longint'($signed(d[15:0]));
                fwd = longint'($signed(d[31:16]));
                if (neg_lat) lat = -lat;
                if (neg_fwd) fwd = -fwd;
                ang_sin = d[47:32] & ANGLE_MASK;
                ang_cos = ang_sin + 16'd16384;
                s = bam_sine(ang_sin);
                c = bam_sine(ang_cos);
                ax = round_shift(lat * c + fwd * s, 15);
                ay = round_shift(fwd * c - lat * s, 15);
                update_axis(0, ax, odx);
                update_axis(1, ay, ody);
                ticks++;
            end
            p.pos_x = pos[0][31:0];
            p.pos_y = pos[1][31:0];
            p.vel_x = vel[0][31:0];
            p.vel_y = vel[1][31:0];
            expected_poses.push_back(p);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, $signed(want), $signed(got));
            end
        endfunction

        function void check_pose(logic [127:0] data);
            pose_t got;
            pose_t want;
            got = pose_t'(data);
            if (expected_poses.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, actual %h", $time, data);
                return;
            end
            want = expected_poses.pop_front();
            checked++;
            compare_field("fused_pos_x", want.pos_x, got.pos_x);
            compare_field("fused_pos_y", want.pos_y, got.pos_y);
            compare_field("velocity_x", want.vel_x, got.vel_x);
            compare_field("velocity_y", want.vel_y, got.vel_y);
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [111:0] i_s_tdata = '0;   // accel_lateral, accel_forward, heading_angle,
                                    // odom_pos_x, odom_pos_y
    logic         i_s_tuser = 1'b0; // command
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [127:0] o_m_tdata;        // fused_pos_x, fused_pos_y, velocity_x, velocity_y

    fusion_scoreboard sb;
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;
    int stall_left = 0;
    int settings_used = 0;
    logic [31:0] track_x = '0;
    logic [31:0] track_y = '0;
    logic [15:0] track_heading = '0;

    imu_odometry_complementary_fusion_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_pose(o_m_tdata);
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
            if (hold_off_req && !hold_off_done) begin
                hold_off_done <= 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 17);
            end
        end
    end

    task automatic write_register(logic [2:0] idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, value);
    endtask

    task automatic apply_settings(logic [15:0] alpha, logic [15:0] decay, logic [15:0] period,
                                  logic fneg, logic lneg);
        @(posedge i_clk);
        write_register(CFG_BLEND_ALPHA, alpha);
        write_register(CFG_VELOCITY_DECAY, decay);
        write_register(CFG_TICK_PERIOD, period);
        write_register(CFG_FORWARD_NEGATE, {15'($urandom), fneg});
        write_register(CFG_LATERAL_NEGATE, {15'($urandom), lneg});
        // unused indexes must be ignored
        for (int i = CFG_LATERAL_NEGATE + 1; i < 8; i++) begin
            write_register(3'(i), 16'($urandom));
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_item(logic cmd, logic [15:0] lat, logic [15:0] fwd, logic [15:0] head,
                             logic [31:0] ox, logic [31:0] oy);
        int gap;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= {oy, ox, head, fwd, lat};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(cmd, {oy, ox, head, fwd, lat});
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_accel();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(0, 4096)) - 16'd2048;
        endcase
    endfunction

    function automatic logic [31:0] pick_odom(logic [31:0] track);
        case ($urandom_range(0, 15))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return track;
        endcase
    endfunction

    function automatic logic [15:0] pick_reg(logic [15:0] lo, logic [15:0] hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random();
        logic cmd;
        cmd = ($urandom_range(0, 24) == 0);
        track_x += 32'($urandom_range(0, 8192)) - 32'd4096;
        track_y += 32'($urandom_range(0, 8192)) - 32'd4096;
        if ($urandom_range(0, 3) == 0) begin
            track_heading = 16'($urandom);
        end else begin
            track_heading += 16'($urandom_range(0, 1024)) - 16'd512;
        end
        send_item(cmd, pick_accel(), pick_accel(), track_heading,
                  pick_odom(track_x), pick_odom(track_y));
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: seed, quadrants, extremes
        send_item(1'b1, 16'h1234, 16'hBEEF, 16'h5A5A, 32'd0, 32'd0);
        send_item(1'b0, 16'h7FFF, 16'h0000, 16'd0, 32'd0, 32'd0);
        send_item(1'b0, 16'h8000, 16'h8000, 16'd16384, 32'd100, -32'sd100);
        send_item(1'b0, 16'h0000, 16'h7FFF, 16'd32768, 32'd200, 32'd300);
        send_item(1'b0, 16'd4096, -16'sd4096, 16'd49152, 32'd0, 32'd0);
        send_item(1'b0, 16'h7FFF, 16'h7FFF, 16'hFFFF, 32'd0, 32'd0);
        send_item(1'b0, -16'sd4096, 16'd2048, 16'd63, 32'd0, 32'd0);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(1'b0, 16'h7FFF, 16'h7FFF, 16'd8192, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(1'b0, 16'h8000, 16'h8000, 16'd40960, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(1'b0, 16'h8000, 16'h7FFF, 16'd24576, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_drained();

        // full-scale gains with both axes negated: drive the accumulators to clamp
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        send_item(1'b1, 16'h0000, 16'h0000, 16'h0000, 32'd0, 32'd0);
        for (int i = 0; i < 7; i++) begin
            send_item(1'b0, (i % 2) ? 16'h7FFF : 16'h8000, (i % 2) ? 16'h7FFF : 16'h8000,
                      16'(i * 9000), 32'h7FFF_FFFF, 32'h8000_0000);
        end
        send_item(1'b0, 16'h8000, 16'h8000, 16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_drained();

        // zero period and zero gains: position follows odometry
        apply_settings(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1);
        send_item(1'b0, 16'h7FFF, 16'h8000, 16'd12345, 32'd5000, -32'sd5000);
        send_item(1'b0, 16'h8000, 16'h7FFF, 16'd54321, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(1'b0, 16'h0000, 16'h0000, 16'd0, 32'd0, 32'd0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            if (ph == RANDOM_PHASES - 1) begin
                src_idle_en = 1'b0;
                snk_idle_en <= 1'b0;
            end
            case (ph)
                0: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'($urandom), 1'($urandom));
                1: apply_settings(16'h0000, 16'h0000, 16'd1, 1'($urandom), 1'($urandom));
                2: apply_settings(16'd64225, 16'd64881, 16'd1311, 1'b0, 1'b0);
                default: apply_settings(pick_reg(16'h0000, 16'hFFFF), pick_reg(16'h0000, 16'hFFFF),
                                        pick_reg(16'd1, 16'hFFFF), 1'($urandom), 1'($urandom));
            endcase
            if (ph == 3) begin
                hold_off_req <= 1'b1;
            end
            repeat (PHASE_ITEMS) send_random();
        end

        wait_drained();
        repeat (64) @(posedge i_clk);
        $display("Run covered %0d ticks and %0d seed commands under %0d register settings.",
                 sb.ticks, sb.seeds, settings_used);
        $display("%0d poses checked, with idle and stall bursts and one long output hold-off.",
                 sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d poses still expected.", sb.pending());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/imuf_pkg.sv
src/imuf_front.sv
src/imuf_queue.sv
src/imuf_back.sv
src/imu_odometry_complementary_fusion_core.sv
tb/testbench.sv
